[src/bbr_pkg.sv]
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants for the bounding box reduction
// Item record passed from front to back, register indexes, float compare.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int unsigned AXES = 3;

	typedef enum logic [1:0] {
		REG_MERGE_MODE    = 2'd0,
		REG_BLK_LEN       = 2'd1,
		REG_ELEMENT_COUNT = 2'd2
	} reg_idx_t;

	// one classified item: bounds to fold plus block bookkeeping
	typedef struct packed {
		logic [AXES-1:0][31:0] lo;
		logic [AXES-1:0][31:0] hi;
		logic                  seed;
		logic                  emit;
		logic                  last;
		logic [23:0]           block_number;
	} item_t;

	// a < b on float bits; a NaN on either side never compares less; -0 == +0
	function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
		logic both_zero;
		logic a_nan;
		logic b_nan;
		both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		a_nan     = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan     = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		if (a_nan || b_nan)
			return 1'b0;
		else if (both_zero)
			return 1'b0;
		else if (a[31] != b[31])
			return a[31];
		else if (!a[31])
			return a[30:0] < b[30:0];
		else
			return a[30:0] > b[30:0];
	endfunction

endpackage

[src/blockwise_bounding_box_reduce.sv]
// ----------------------------------------------------------------------------
// blockwise_bounding_box_reduce: per-block AABB of a float 3D stream
// Top level: config registers, front classifier, item queue, folder, result queue.
// ----------------------------------------------------------------------------
// One item is taken per cycle, back to back, while full is low. The front classifies
// an item at its accepting edge and writes it into a two-entry item queue; the back
// folds it into the running bounds at the edge at which it takes it from the queue head.
// A closing item's box enters the result queue at that same edge, and empty falls after
// that edge. The sustained rate is one item per cycle while results are popped; a full
// result queue stalls only the items that close a block, then the item queue fills and
// full rises.
module blockwise_bounding_box_reduce #(
	parameter int unsigned QDEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] lo_x,
	input  logic [31:0] lo_y,
	input  logic [31:0] lo_z,
	input  logic [31:0] hi_x,
	input  logic [31:0] hi_y,
	input  logic [31:0] hi_z,
	output logic        empty,
	input  logic        pop,
	output logic [23:0] block_number,
	output logic [31:0] min_x,
	output logic [31:0] min_y,
	output logic [31:0] min_z,
	output logic [31:0] max_x,
	output logic [31:0] max_y,
	output logic [31:0] max_z,
	output logic        last_block,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned IW = $bits(bbr_pkg::item_t);
	localparam int unsigned RW = 24 + 6*32 + 1;

	logic           merge_mode_q;
	logic [16:0]    blk_len_q;
	logic [24:0]    element_count_q;
	bbr_pkg::item_t fr_item;
	bbr_pkg::item_t bk_item;
	logic           iq_empty;
	logic           bk_take;
	logic           res_wr;
	logic           res_full;
	logic [RW-1:0]  res_wdata;
	logic [RW-1:0]  res_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_mode_q    <= 1'b0;
			blk_len_q       <= 17'd256;
			element_count_q <= 25'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				bbr_pkg::REG_MERGE_MODE:    merge_mode_q    <= cfg_data[0];
				bbr_pkg::REG_BLK_LEN:       blk_len_q       <= cfg_data[16:0];
				bbr_pkg::REG_ELEMENT_COUNT: element_count_q <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	bbr_front u_front (
		.clk(clk), .arst_n(arst_n), .take(push && !full),
		.lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z),
		.hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
		.merge_mode(merge_mode_q), .blk_len(blk_len_q),
		.element_count(element_count_q), .item(fr_item)
	);

	bbr_queue #(.WIDTH(IW), .DEPTH(QDEPTH)) u_iq (
		.clk(clk), .arst_n(arst_n),
		.wr(push), .wdata(fr_item), .full(full),
		.rd(bk_take), .rdata(bk_item), .empty(iq_empty)
	);

	bbr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(!iq_empty), .item(bk_item), .item_take(bk_take),
		.res_wr(res_wr), .res_data(res_wdata), .res_full(res_full)
	);

	bbr_queue #(.WIDTH(RW), .DEPTH(QDEPTH)) u_rq (
		.clk(clk), .arst_n(arst_n),
		.wr(res_wr), .wdata(res_wdata), .full(res_full),
		.rd(pop), .rdata(res_rdata), .empty(empty)
	);

	assign {block_number, min_x, min_y, min_z, max_x, max_y, max_z, last_block} =
		{res_rdata[RW-1 -: 24],
		 res_rdata[0+1+3*32+0*32 +: 32], res_rdata[1+3*32+1*32 +: 32],
		 res_rdata[1+3*32+2*32 +: 32],
		 res_rdata[1+0*32 +: 32], res_rdata[1+1*32 +: 32], res_rdata[1+2*32 +: 32],
		 res_rdata[0]};

`ifndef SYNTHESIS
	a_res_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr) |=> !empty)
		else $error("emitted box not visible");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port stalled");
	a_last_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr && res_wdata[0]) |-> (bk_item.emit))
		else $error("last flag without emit");
`endif

endmodule

[src/bbr_front.sv]
// ----------------------------------------------------------------------------
// bbr_front: item intake and classification
// Tracks block position and pass count; tags each item with seed/emit/last.
// ----------------------------------------------------------------------------
module bbr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [31:0]         lo_x,
	input  logic [31:0]         lo_y,
	input  logic [31:0]         lo_z,
	input  logic [31:0]         hi_x,
	input  logic [31:0]         hi_y,
	input  logic [31:0]         hi_z,
	input  logic                merge_mode,
	input  logic [16:0]         blk_len,
	input  logic [24:0]         element_count,
	output bbr_pkg::item_t      item
);

	logic [16:0] pos_q;
	logic [24:0] seen_q;
	logic [23:0] blk_q;
	logic [16:0] eff_size;
	logic [24:0] eff_count;
	logic [16:0] pos_nx;
	logic [24:0] seen_nx;

	always_comb begin
		eff_size  = (blk_len == 17'd0) ? 17'd1 :
			(blk_len > 17'd65536) ? 17'd65536 : blk_len;
		eff_count = (element_count == 25'd0) ? 25'd1 : element_count;
		pos_nx    = pos_q + 17'd1;
		seen_nx   = seen_q + 25'd1;
		item.lo   = {lo_z, lo_y, lo_x};
		item.hi   = merge_mode ? {hi_z, hi_y, hi_x} : {lo_z, lo_y, lo_x};
		item.seed = (pos_q == 17'd0);
		item.last = (seen_nx >= eff_count);
		item.emit = item.last || (pos_nx >= eff_size);
		item.block_number = blk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= '0;
			blk_q  <= '0;
		end else if (take) begin
			if (item.emit) begin
				pos_q <= '0;
				if (item.last) begin
					seen_q <= '0;
					blk_q  <= '0;
				end else begin
					seen_q <= seen_nx;
					blk_q  <= blk_q + 24'd1;
				end
			end else begin
				pos_q  <= pos_nx;
				seen_q <= seen_nx;
			end
		end
	end

endmodule

[src/bbr_queue.sv]
// ----------------------------------------------------------------------------
// bbr_queue: small FIFO of records
// Decouples front from back and back from the result port; registered storage, no pass-through.
// ----------------------------------------------------------------------------
module bbr_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (rd && !empty)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> (cnt_q == (AW+1)'(DEPTH)) || $fell(full))
		else $error("queue count left full state illegally");
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && wr) |=> !empty)
		else $error("write into empty queue lost");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

[src/bbr_back.sv]
// ----------------------------------------------------------------------------
// bbr_back: bound folding
// Folds each item into running min/max; an emitting item pushes a result.
// ----------------------------------------------------------------------------
module bbr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  bbr_pkg::item_t      item,
	output logic                item_take,
	output logic                res_wr,
	output logic [24+6*32:0]    res_data,
	input  logic                res_full
);

	logic [bbr_pkg::AXES-1:0][31:0] low_q;
	logic [bbr_pkg::AXES-1:0][31:0] high_q;
	logic [bbr_pkg::AXES-1:0][31:0] low_nx;
	logic [bbr_pkg::AXES-1:0][31:0] high_nx;

	always_comb begin
		for (int d = 0; d < bbr_pkg::AXES; d++) begin
			low_nx[d]  = (item.seed || bbr_pkg::flt_lt(item.lo[d], low_q[d])) ?
				item.lo[d] : low_q[d];
			high_nx[d] = (item.seed || bbr_pkg::flt_lt(high_q[d], item.hi[d])) ?
				item.hi[d] : high_q[d];
		end
		// a non-emitting item never waits on the result side
		item_take = item_valid && (!item.emit || !res_full);
		res_wr    = item_take && item.emit;
		res_data  = {item.block_number, low_nx, high_nx, item.last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (item_take) begin
			low_q  <= low_nx;
			high_q <= high_nx;
		end
	end

`ifndef SYNTHESIS
	a_emit_push: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item.emit) |-> !res_full)
		else $error("result written into full queue");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!item_take |=> $stable(low_q) && $stable(high_q))
		else $error("bounds changed with no transfer");
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item.last) |-> item.emit)
		else $error("last item not emitting");
`endif

endmodule

[tb/sv/blockwise_bounding_box_reduce_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blockwise_bounding_box_reduce_tb: self-checking bench for the box reduction
// Directed table then random float streams over several register settings;
// every popped box is compared against a behavioural fold of the same items.
// ----------------------------------------------------------------------------
module blockwise_bounding_box_reduce_tb;

	typedef struct packed {
		logic [23:0] blk;
		logic [31:0] mnx, mny, mnz, mxx, mxy, mxz;
		logic        lst;
	} box_t;

	typedef struct {
		logic [31:0] lo[3];
		logic [31:0] hi[3];
		bit          has_box;
		box_t        box;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] lo_x = '0, lo_y = '0, lo_z = '0, hi_x = '0, hi_y = '0, hi_z = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [23:0] block_number;
	logic [31:0] min_x, min_y, min_z, max_x, max_y, max_z;
	logic        last_block;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic        mode_q;
	logic [16:0] bsize_q;
	logic [24:0] ecount_q;
	logic [31:0] run_lo[3];
	logic [31:0] run_hi[3];
	logic [16:0] pos_q;
	logic [24:0] seen_q;
	logic [23:0] blk_q;

	box_t  pending_boxes[$];
	box_t  typed_boxes[$];
	int    errors = 0;
	int    push_idle = 0, pop_idle = 0;
	row_t  dir_rows[$];

	always #10 clk = ~clk;

	blockwise_bounding_box_reduce u_top (.*);

	// float a < b on raw bits; a NaN never compares less; signed zeros equal
	function automatic bit fless(logic [31:0] a, logic [31:0] b);
		if (a[30:23] == 8'hff && a[22:0] != 0) return 0;
		if (b[30:23] == 8'hff && b[22:0] != 0) return 0;
		if (a[30:0] == 0 && b[30:0] == 0) return 0;
		if (a[31] != b[31]) return a[31];
		if (!a[31]) return a[30:0] < b[30:0];
		return a[30:0] > b[30:0];
	endfunction

	function automatic void fold_item(logic [31:0] lo[3], logic [31:0] hi_in[3]);
		logic [31:0] hi[3];
		logic [16:0] esz;
		logic [24:0] ecnt;
		bit lst;
		box_t b;
		esz = (bsize_q == 0) ? 17'd1 : (bsize_q > 65536 ? 17'd65536 : bsize_q);
		ecnt = (ecount_q == 0) ? 25'd1 : ecount_q;
		for (int d = 0; d < 3; d++) begin
			hi[d] = mode_q ? hi_in[d] : lo[d];
			if (pos_q == 0) begin
				run_lo[d] = lo[d];
				run_hi[d] = hi[d];
			end else begin
				if (fless(lo[d], run_lo[d])) run_lo[d] = lo[d];
				if (fless(run_hi[d], hi[d])) run_hi[d] = hi[d];
			end
		end
		pos_q++;
		seen_q++;
		lst = seen_q >= ecnt;
		if (!lst && pos_q < esz) return;
		b = '{blk_q, run_lo[0], run_lo[1], run_lo[2], run_hi[0], run_hi[1], run_hi[2], lst};
		pending_boxes.push_back(b);
		pos_q = 0;
		if (lst) begin
			seen_q = 0;
			blk_q = 0;
		end else blk_q++;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result side: sample at the rising edge, change pop at the falling edge
	always @(posedge clk) begin
		box_t w;
		if (arst_n && pop && !empty) begin
			if (pending_boxes.size() == 0) begin
				report_mismatch("unexpected box", {8'd0, block_number}, 32'd0);
			end else begin
				w = pending_boxes.pop_front();
				if (typed_boxes.size() > 0) begin
					if (typed_boxes.pop_front() !== w)
						report_mismatch("typed row vs predictor", 0, 1);
				end
				if (block_number !== w.blk)
					report_mismatch("block_number", {8'd0, block_number}, {8'd0, w.blk});
				if (min_x !== w.mnx) report_mismatch("min_x", min_x, w.mnx);
				if (min_y !== w.mny) report_mismatch("min_y", min_y, w.mny);
				if (min_z !== w.mnz) report_mismatch("min_z", min_z, w.mnz);
				if (max_x !== w.mxx) report_mismatch("max_x", max_x, w.mxx);
				if (max_y !== w.mxy) report_mismatch("max_y", max_y, w.mxy);
				if (max_z !== w.mxz) report_mismatch("max_z", max_z, w.mxz);
				if (last_block !== w.lst)
					report_mismatch("last_block", {31'd0, last_block}, {31'd0, w.lst});
			end
		end
	end

	always @(negedge clk) pop <= ($urandom_range(99) >= pop_idle);

	// waits for a further falling edge after valid drops, so back to back writes never
	// assign cfg_valid twice in one step
	task automatic write_reg(bbr_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			bbr_pkg::REG_MERGE_MODE:    mode_q = val[0];
			bbr_pkg::REG_BLK_LEN:       bsize_q = val[16:0];
			bbr_pkg::REG_ELEMENT_COUNT: ecount_q = val[24:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// push stays high on return; the next send or drain decides its level
	task automatic send_item(logic [31:0] lo[3], logic [31:0] hi[3]);
		while ($urandom_range(99) < push_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		{lo_x, lo_y, lo_z} <= {lo[0], lo[1], lo[2]};
		{hi_x, hi_y, hi_z} <= {hi[0], hi[1], hi[2]};
		push <= 1'b1;
		do @(posedge clk); while (full);
		fold_item(lo, hi);
		@(negedge clk);
	endtask

	task automatic drain;
		push <= 1'b0;
		while (pending_boxes.size() > 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// mostly finite floats near one so comparisons contend; some raw bit patterns
	function automatic logic [31:0] rand_float();
		case ($urandom_range(9))
			0: return $urandom();
			1: return {1'($urandom_range(1)), 31'd0};
			2: return {1'($urandom_range(1)), 8'hff, 23'd0};
			3: return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
			default: return {1'($urandom_range(1)), 8'($urandom_range(120, 134)),
					23'($urandom_range(3) << 21)};
		endcase
	endfunction

	task automatic random_phase(bit m, int bs, int ec, int n);
		logic [31:0] lo[3], hi[3];
		write_reg(bbr_pkg::REG_MERGE_MODE, 32'(m));
		write_reg(bbr_pkg::REG_BLK_LEN, bs);
		write_reg(bbr_pkg::REG_ELEMENT_COUNT, ec);
		for (int i = 0; i < n; i++) begin
			for (int d = 0; d < 3; d++) begin
				lo[d] = rand_float();
				hi[d] = rand_float();
			end
			send_item(lo, hi);
		end
		drain();
	endtask

	function automatic row_t mk(logic [31:0] a, logic [31:0] b, bit has, box_t bx);
		row_t r;
		r.lo = '{a, a, a};
		r.hi = '{b, b, b};
		r.has_box = has;
		r.box = bx;
		return r;
	endfunction

	initial begin
		mode_q = 0; bsize_q = 256; ecount_q = 1;
		pos_q = 0; seen_q = 0; blk_q = 0;
		run_lo = '{0, 0, 0}; run_hi = '{0, 0, 0};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// after reset: element count 1, each item is a whole pass on its own
		dir_rows.push_back(mk(32'h3f800000, 32'h0, 1, '{0, 32'h3f800000, 32'h3f800000,
			32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000, 1}));
		dir_rows.push_back(mk(32'hffffffff, 32'hffffffff, 1, '{0, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1}));
		foreach (dir_rows[i]) begin
			typed_boxes.push_back(dir_rows[i].box);
			send_item(dir_rows[i].lo, dir_rows[i].hi);
		end
		drain();
		dir_rows.delete();

		// merge mode, block of 4, ties of signed zeros, infinities, short final block
		write_reg(bbr_pkg::REG_MERGE_MODE, 1);
		write_reg(bbr_pkg::REG_BLK_LEN, 4);
		write_reg(bbr_pkg::REG_ELEMENT_COUNT, 10);
		dir_rows.push_back(mk(32'h80000000, 32'h00000000, 0, '0));
		dir_rows.push_back(mk(32'h00000000, 32'h80000000, 0, '0));
		dir_rows.push_back(mk(32'hff800000, 32'h7f800000, 0, '0));
		dir_rows.push_back(mk(32'h00000001, 32'h80000001, 0, '0));
		dir_rows.push_back(mk(32'h7f7fffff, 32'hff7fffff, 0, '0));
		dir_rows.push_back(mk(32'h7fc00000, 32'h7fc00000, 0, '0));
		dir_rows.push_back(mk(32'h3f800000, 32'hbf800000, 0, '0));
		dir_rows.push_back(mk(32'hc0000000, 32'h40000000, 0, '0));
		dir_rows.push_back(mk(32'h00000000, 32'h00000000, 0, '0));
		dir_rows.push_back(mk(32'h80000000, 32'h80000000, 0, '0));
		foreach (dir_rows[i]) send_item(dir_rows[i].lo, dir_rows[i].hi);
		drain();
		// zero size and zero count are taken as one; oversized block clamps
		write_reg(bbr_pkg::REG_BLK_LEN, 0);
		write_reg(bbr_pkg::REG_ELEMENT_COUNT, 0);
		foreach (dir_rows[i]) if (i < 3) send_item(dir_rows[i].lo, dir_rows[i].hi);
		drain();
		write_reg(bbr_pkg::REG_BLK_LEN, 32'h1ffff);
		write_reg(bbr_pkg::REG_ELEMENT_COUNT, 32'h1ffffff);
		write_reg(bbr_pkg::REG_ELEMENT_COUNT, 3);
		foreach (dir_rows[i]) if (i < 4) send_item(dir_rows[i].lo, dir_rows[i].hi);
		drain();

		push_idle = 36; pop_idle = 75;
		random_phase(0, 1, 200, 200);
		random_phase(1, 7, 150, 150);
		random_phase(0, 16, 37, 150);
		push_idle = 75; pop_idle = 36;
		random_phase(1, 3, 100, 150);
		random_phase(0, 65536, 40, 120);
		random_phase(1, 65537, 16777216, 60);
		write_reg(bbr_pkg::REG_ELEMENT_COUNT, 1);
		random_phase(1, 2, 1, 30);
		push_idle = 0; pop_idle = 0;
		random_phase(0, 5, 90, 250);
		random_phase(1, 1, 25, 200);
		random_phase(1, 31, 300, 300);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
src/bbr_pkg.sv
src/bbr_front.sv
src/bbr_queue.sv
src/bbr_back.sv
src/blockwise_bounding_box_reduce.sv
tb/sv/blockwise_bounding_box_reduce_tb.sv
